@@ src/lowest_positive_quadratic_root_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers shared by the quadratic root unit.
// ----------------------------------------------------------------------------
`ifndef LOWEST_POSITIVE_QUADRATIC_ROOT_UNIT_ASSERT_SVH
`define LOWEST_POSITIVE_QUADRATIC_ROOT_UNIT_ASSERT_SVH

// property must hold at every edge outside reset
`define LPQR_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// condition must never be seen outside reset
`define LPQR_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

@@ src/lpqr_pkg.sv @@
// ----------------------------------------------------------------------------
// lpqr_pkg
// Shared constants for the lowest positive quadratic root unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lpqr_pkg;

   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;

endpackage

`default_nettype wire

@@ src/lpqr_sqrt.sv @@
// ----------------------------------------------------------------------------
// lpqr_sqrt
// Pipelined restoring integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module lpqr_sqrt #(
   parameter int ROOT_W = lpqr_pkg::DATA_WIDTH_DEF + 1,
   parameter int SIDE_W = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  en,
   input  wire logic                  in_valid,
   input  wire logic [2*ROOT_W-1:0]   rad,
   input  wire logic [SIDE_W-1:0]     side_in,
   output logic                       out_valid,
   output logic [ROOT_W-1:0]          root,
   output logic [SIDE_W-1:0]          side_out
);

   localparam int RAD_W = 2 * ROOT_W;
   localparam int REM_W = ROOT_W + 3;

   logic              v_ff    [ROOT_W];
   logic [RAD_W-1:0]  rad_ff  [ROOT_W];
   logic [REM_W-1:0]  rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [SIDE_W-1:0] side_ff [ROOT_W];

   logic              v_src    [ROOT_W];
   logic [RAD_W-1:0]  rad_src  [ROOT_W];
   logic [REM_W-1:0]  rem_src  [ROOT_W];
   logic [ROOT_W-1:0] root_src [ROOT_W];
   logic [SIDE_W-1:0] side_src [ROOT_W];

   logic [REM_W-1:0]  rem_sh   [ROOT_W];
   logic [REM_W-1:0]  trial    [ROOT_W];
   logic              ge       [ROOT_W];
   logic [REM_W-1:0]  rem_in   [ROOT_W];
   logic [ROOT_W-1:0] root_in  [ROOT_W];
   logic [RAD_W-1:0]  rad_in   [ROOT_W];

   for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
      if (g == 0) begin : g_first
         assign v_src[g]    = in_valid;
         assign rad_src[g]  = rad;
         assign rem_src[g]  = '0;
         assign root_src[g] = '0;
         assign side_src[g] = side_in;
      end else begin : g_next
         assign v_src[g]    = v_ff[g-1];
         assign rad_src[g]  = rad_ff[g-1];
         assign rem_src[g]  = rem_ff[g-1];
         assign root_src[g] = root_ff[g-1];
         assign side_src[g] = side_ff[g-1];
      end

      // bring down the next radicand pair, try (2r)*2+1
      assign rem_sh[g]  = {rem_src[g][REM_W-3:0], rad_src[g][RAD_W-1 -: 2]};
      assign trial[g]   = {1'b0, root_src[g], 2'b01};
      assign ge[g]      = rem_sh[g] >= trial[g];
      assign rem_in[g]  = ge[g] ? (rem_sh[g] - trial[g]) : rem_sh[g];
      assign root_in[g] = {root_src[g][ROOT_W-2:0], ge[g]};
      assign rad_in[g]  = {rad_src[g][RAD_W-3:0], 2'b00};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[g] <= 1'b0;
         end else if (en) begin
            v_ff[g] <= v_src[g];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[g]  <= rad_in[g];
            rem_ff[g]  <= rem_in[g];
            root_ff[g] <= root_in[g];
            side_ff[g] <= side_src[g];
         end
      end
   end

   assign out_valid = v_ff[ROOT_W-1];
   assign root      = root_ff[ROOT_W-1];
   assign side_out  = side_ff[ROOT_W-1];

endmodule

`default_nettype wire

@@ src/lpqr_div.sv @@
// ----------------------------------------------------------------------------
// lpqr_div
// Pipelined restoring unsigned divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module lpqr_div #(
   parameter int NUM_W  = 50,
   parameter int DIV_W  = 33,
   parameter int SIDE_W = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               en,
   input  wire logic               in_valid,
   input  wire logic [NUM_W-1:0]   num,
   input  wire logic [DIV_W-1:0]   den,
   input  wire logic [SIDE_W-1:0]  side_in,
   output logic                    out_valid,
   output logic [NUM_W-1:0]        quo,
   output logic [SIDE_W-1:0]       side_out
);

   logic              v_ff    [NUM_W];
   logic [NUM_W-1:0]  num_ff  [NUM_W];
   logic [DIV_W-1:0]  den_ff  [NUM_W];
   logic [DIV_W-1:0]  rem_ff  [NUM_W];
   logic [NUM_W-1:0]  quo_ff  [NUM_W];
   logic [SIDE_W-1:0] side_ff [NUM_W];

   logic              v_src    [NUM_W];
   logic [NUM_W-1:0]  num_src  [NUM_W];
   logic [DIV_W-1:0]  den_src  [NUM_W];
   logic [DIV_W-1:0]  rem_src  [NUM_W];
   logic [NUM_W-1:0]  quo_src  [NUM_W];
   logic [SIDE_W-1:0] side_src [NUM_W];

   logic [DIV_W:0]    rem_sh   [NUM_W];
   logic [DIV_W:0]    diff     [NUM_W];
   logic              ge       [NUM_W];
   logic [DIV_W-1:0]  rem_in   [NUM_W];

   for (genvar g = 0; g < NUM_W; g++) begin : g_stage
      if (g == 0) begin : g_first
         assign v_src[g]    = in_valid;
         assign num_src[g]  = num;
         assign den_src[g]  = den;
         assign rem_src[g]  = '0;
         assign quo_src[g]  = '0;
         assign side_src[g] = side_in;
      end else begin : g_next
         assign v_src[g]    = v_ff[g-1];
         assign num_src[g]  = num_ff[g-1];
         assign den_src[g]  = den_ff[g-1];
         assign rem_src[g]  = rem_ff[g-1];
         assign quo_src[g]  = quo_ff[g-1];
         assign side_src[g] = side_ff[g-1];
      end

      assign rem_sh[g] = {rem_src[g], num_src[g][NUM_W-1]};
      assign diff[g]   = rem_sh[g] - {1'b0, den_src[g]};
      assign ge[g]     = rem_sh[g] >= {1'b0, den_src[g]};
      assign rem_in[g] = ge[g] ? diff[g][DIV_W-1:0] : rem_sh[g][DIV_W-1:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[g] <= 1'b0;
         end else if (en) begin
            v_ff[g] <= v_src[g];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            num_ff[g]  <= {num_src[g][NUM_W-2:0], 1'b0};
            den_ff[g]  <= den_src[g];
            rem_ff[g]  <= rem_in[g];
            quo_ff[g]  <= {quo_src[g][NUM_W-2:0], ge[g]};
            side_ff[g] <= side_src[g];
         end
      end
   end

   assign out_valid = v_ff[NUM_W-1];
   assign quo       = quo_ff[NUM_W-1];
   assign side_out  = side_ff[NUM_W-1];

endmodule

`default_nettype wire

@@ src/lowest_positive_quadratic_root_unit.sv @@
// Lowest positive quadratic root unit. Each item carries a, b, c and an
// exclusive upper limit in signed fixed point; the result is the smallest
// root of a*x^2+b*x+c that lies strictly between zero and the limit, with a
// found flag (a of zero or a negative discriminant gives no root). The unit
// is a straight pipeline (default format Q16.16) and takes one item per
// clock. Its stages are three registers for decode, the two multiplies
// and the discriminant, one per bit of the square root, the numerators,
// one per quotient bit of the two parallel dividers, then saturation and
// root selection. When the output item is not taken the whole pipeline holds.
// ----------------------------------------------------------------------------
// lowest_positive_quadratic_root_unit
// Top level: discriminant, square root, root division and selection.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lowest_positive_quadratic_root_unit_assert.svh"

module lowest_positive_quadratic_root_unit #(
   parameter int DATA_WIDTH = lpqr_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = lpqr_pkg::FRAC_BITS_DEF
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   // coef_a, coef_b, coef_c, upper_limit
   input  wire logic [((4*DATA_WIDTH+7)/8)*8-1:0]       req_tdata,
   input  wire logic                                    req_tvalid,
   output logic                                         req_tready,
   // root_value
   output logic [((DATA_WIDTH-1+7)/8)*8-1:0]            rsp_tdata,
   // found
   output logic [0:0]                                   rsp_tuser,
   output logic                                         rsp_tvalid,
   input  wire logic                                    rsp_tready
);

   localparam int W     = DATA_WIDTH;
   localparam int SW    = W + 1;           // square root width
   localparam int MW    = W + 2;           // |-b +/- s|
   localparam int NW    = W + 3;           // signed -b +/- s
   localparam int QW    = MW + FRAC_BITS;  // dividend and quotient
   localparam int DVW   = W + 1;           // 2|a|
   localparam int SQ_SW = 3 * W + 2;
   localparam int D1_SW = W + 3;
   localparam int RSP_W = ((W - 1 + 7) / 8) * 8;

   logic en;

   // stage 1: magnitudes
   logic         s1_v_ff;
   logic         s1_an_ff, s1_cn_ff, s1_az_ff;
   logic [W-1:0] s1_am_ff, s1_bm_ff, s1_cm_ff, s1_b_ff, s1_lim_ff;
   logic [W-1:0] a_raw, b_raw, c_raw;

   // stage 2: products
   logic           s2_v_ff;
   logic           s2_an_ff, s2_qneg_ff, s2_az_ff;
   logic [W-1:0]   s2_am_ff, s2_b_ff, s2_lim_ff;
   logic [2*W-1:0] s2_pp_ff, s2_ac_ff;

   // stage 3: discriminant
   logic            s3_v_ff;
   logic [2*SW-1:0] s3_disc_ff;
   logic [SQ_SW-1:0] s3_side_ff;
   logic [2*W+1:0]  disc_sum;
   logic [2*W+2:0]  disc_diff;
   logic [2*W+1:0]  q4;

   // square root
   logic             sq_v;
   logic [SW-1:0]    sq_root;
   logic [SQ_SW-1:0] sq_side;
   logic             sq_an, sq_nr;
   logic [W-1:0]     sq_am, sq_b, sq_lim;

   // stage after root: numerators
   logic          p1_v_ff;
   logic          p1_an_ff, p1_nr_ff, p1_n1n_ff, p1_n2n_ff;
   logic [W-1:0]  p1_am_ff, p1_lim_ff;
   logic [MW-1:0] p1_m1_ff, p1_m2_ff;
   logic [NW-1:0] sb_ext, s_ext, n1, n2, n1_neg, n2_neg;

   // dividers
   logic             d1_v, d2_v;
   logic [QW-1:0]    d1_q, d2_q;
   logic [D1_SW-1:0] d1_side;
   logic [0:0]       d2_side;
   logic             d_nr, d_an, d_n1n;
   logic [W-1:0]     d_lim;

   // stage after division: saturated roots
   logic         p2_v_ff, p2_nr_ff;
   logic [W-1:0] p2_x1_ff, p2_x2_ff, p2_lim_ff;
   logic [W-1:0] x1_sat, x2_sat;

   // root selection
   logic [W-1:0] lo, hi;
   logic         lo_ok, hi_ok;

   logic             rsp_valid_ff;
   logic             rsp_found_ff;
   logic [W-2:0]     rsp_root_ff;

   function automatic logic [W-1:0] sat_quo(input logic [QW-1:0] q, input logic neg);
      logic [W-1:0] r;
      if (!neg) begin
         r = (|q[QW-1:W-1]) ? {1'b0, {(W-1){1'b1}}} : q[W-1:0];
      end else if ((|q[QW-1:W]) || (q[W-1] && (|q[W-2:0]))) begin
         r = {1'b1, {(W-1){1'b0}}};
      end else begin
         r = (~q[W-1:0]) + 1'b1;
      end
      return r;
   endfunction

   assign en         = rsp_tready || !rsp_valid_ff;
   assign req_tready = en;

   assign a_raw = req_tdata[W-1:0];
   assign b_raw = req_tdata[2*W-1:W];
   assign c_raw = req_tdata[3*W-1:2*W];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         s3_v_ff      <= 1'b0;
         p1_v_ff      <= 1'b0;
         p2_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff      <= req_tvalid;
         s2_v_ff      <= s1_v_ff;
         s3_v_ff      <= s2_v_ff;
         p1_v_ff      <= sq_v;
         p2_v_ff      <= d1_v;
         rsp_valid_ff <= p2_v_ff;
      end
   end

   // decode, multiply, discriminant
   assign q4        = {s2_ac_ff, 2'b00};
   assign disc_sum  = {2'b00, s2_pp_ff} + q4;
   assign disc_diff = {3'b000, s2_pp_ff} - {1'b0, q4};

   always_ff @(posedge clock) begin
      if (en) begin
         s1_an_ff  <= a_raw[W-1];
         s1_cn_ff  <= c_raw[W-1];
         s1_az_ff  <= a_raw == '0;
         s1_am_ff  <= a_raw[W-1] ? (~a_raw + 1'b1) : a_raw;
         s1_bm_ff  <= b_raw[W-1] ? (~b_raw + 1'b1) : b_raw;
         s1_cm_ff  <= c_raw[W-1] ? (~c_raw + 1'b1) : c_raw;
         s1_b_ff   <= b_raw;
         s1_lim_ff <= req_tdata[4*W-1:3*W];

         s2_an_ff   <= s1_an_ff;
         s2_qneg_ff <= s1_an_ff ^ s1_cn_ff;
         s2_az_ff   <= s1_az_ff;
         s2_am_ff   <= s1_am_ff;
         s2_b_ff    <= s1_b_ff;
         s2_lim_ff  <= s1_lim_ff;
         s2_pp_ff   <= s1_bm_ff * s1_bm_ff;
         s2_ac_ff   <= s1_am_ff * s1_cm_ff;

         s3_disc_ff <= s2_qneg_ff ? disc_sum : disc_diff[2*W+1:0];
         s3_side_ff <= {s2_an_ff, s2_am_ff, s2_b_ff, s2_lim_ff,
                        s2_az_ff || (!s2_qneg_ff && disc_diff[2*W+2])};
      end
   end

   lpqr_sqrt #(
      .ROOT_W (SW),
      .SIDE_W (SQ_SW)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s3_v_ff),
      .rad       (s3_disc_ff),
      .side_in   (s3_side_ff),
      .out_valid (sq_v),
      .root      (sq_root),
      .side_out  (sq_side)
   );

   assign {sq_an, sq_am, sq_b, sq_lim, sq_nr} = sq_side;

   // -b - s and -b + s, then sign and magnitude
   assign sb_ext = {{3{sq_b[W-1]}}, sq_b};
   assign s_ext  = {2'b00, sq_root};
   assign n1     = (~sb_ext + 1'b1) - s_ext;
   assign n2     = (~sb_ext + 1'b1) + s_ext;
   assign n1_neg = ~n1 + 1'b1;
   assign n2_neg = ~n2 + 1'b1;

   always_ff @(posedge clock) begin
      if (en) begin
         p1_an_ff  <= sq_an;
         p1_nr_ff  <= sq_nr;
         p1_am_ff  <= sq_am;
         p1_lim_ff <= sq_lim;
         p1_n1n_ff <= n1[NW-1];
         p1_n2n_ff <= n2[NW-1];
         p1_m1_ff  <= n1[NW-1] ? n1_neg[MW-1:0] : n1[MW-1:0];
         p1_m2_ff  <= n2[NW-1] ? n2_neg[MW-1:0] : n2[MW-1:0];
      end
   end

   lpqr_div #(
      .NUM_W  (QW),
      .DIV_W  (DVW),
      .SIDE_W (D1_SW)
   ) u_div_lo (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (p1_v_ff),
      .num       ({p1_m1_ff, {FRAC_BITS{1'b0}}}),
      .den       ({p1_am_ff, 1'b0}),
      .side_in   ({p1_nr_ff, p1_an_ff, p1_n1n_ff, p1_lim_ff}),
      .out_valid (d1_v),
      .quo       (d1_q),
      .side_out  (d1_side)
   );

   lpqr_div #(
      .NUM_W  (QW),
      .DIV_W  (DVW),
      .SIDE_W (1)
   ) u_div_hi (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (p1_v_ff),
      .num       ({p1_m2_ff, {FRAC_BITS{1'b0}}}),
      .den       ({p1_am_ff, 1'b0}),
      .side_in   (p1_n2n_ff),
      .out_valid (d2_v),
      .quo       (d2_q),
      .side_out  (d2_side)
   );

   assign {d_nr, d_an, d_n1n, d_lim} = d1_side;

   // a zero quotient is never negative
   assign x1_sat = sat_quo(d1_q, (d_n1n ^ d_an) && (d1_q != '0));
   assign x2_sat = sat_quo(d2_q, (d2_side[0] ^ d_an) && (d2_q != '0));

   always_ff @(posedge clock) begin
      if (en) begin
         p2_nr_ff  <= d_nr;
         p2_x1_ff  <= x1_sat;
         p2_x2_ff  <= x2_sat;
         p2_lim_ff <= d_lim;
      end
   end

   // order the roots and take the lower one inside (0, limit)
   assign lo    = ($signed(p2_x1_ff) > $signed(p2_x2_ff)) ? p2_x2_ff : p2_x1_ff;
   assign hi    = ($signed(p2_x1_ff) > $signed(p2_x2_ff)) ? p2_x1_ff : p2_x2_ff;
   assign lo_ok = ($signed(lo) > $signed({W{1'b0}})) && ($signed(lo) < $signed(p2_lim_ff));
   assign hi_ok = ($signed(hi) > $signed({W{1'b0}})) && ($signed(hi) < $signed(p2_lim_ff));

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_found_ff <= !p2_nr_ff && (lo_ok || hi_ok);
         if (p2_nr_ff) begin
            rsp_root_ff <= '0;
         end else if (lo_ok) begin
            rsp_root_ff <= lo[W-2:0];
         end else if (hi_ok) begin
            rsp_root_ff <= hi[W-2:0];
         end else begin
            rsp_root_ff <= '0;
         end
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tuser[0] = rsp_found_ff;
   assign rsp_tdata    = {{(RSP_W-W+1){1'b0}}, rsp_root_ff};

   `LPQR_ASSERT(a_div_lanes_aligned, d1_v == d2_v, "divider lanes out of step")
   `LPQR_NEVER(a_found_nonzero, rsp_tvalid && rsp_tuser[0] && (rsp_tdata == '0),
      "found root is zero")
   `LPQR_NEVER(a_miss_zero, rsp_tvalid && !rsp_tuser[0] && (rsp_tdata != '0),
      "root value without found")

endmodule

`default_nettype wire

@@ dv/lowest_positive_quadratic_root_unit_tb.sv @@
// ----------------------------------------------------------------------------
// lowest_positive_quadratic_root_unit_tb
// Streams coefficient items (a, b, c, limit) into the root unit and checks
// each result against a wide-integer predictor of the lowest positive root.
// The run covers directed corner cases, then random items under four
// idle/stall phases.
// ----------------------------------------------------------------------------
`default_nettype none

module lowest_positive_quadratic_root_unit_tb;

   localparam int DW        = lpqr_pkg::DATA_WIDTH_DEF;
   localparam int FB        = lpqr_pkg::FRAC_BITS_DEF;
   localparam int LATENCY   = 3 + (DW + 1) + 1 + (DW + 2 + FB) + 2;
   localparam int MAX_CYCLES = 400000;
   localparam logic signed [31:0] ONE  = 32'sd65536;
   localparam logic signed [31:0] SMAX = 32'sh7fffffff;
   localparam logic signed [31:0] SMIN = 32'sh80000000;

   typedef struct packed {
      logic        found;
      logic [30:0] root;
   } root_result_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic [127:0] req_tdata = '0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [31:0]  rsp_tdata;
   logic [0:0]   rsp_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;

   root_result_type expected_roots[$];
   int           error_count = 0;
   int           items_sent = 0;
   int           results_seen = 0;
   int           found_seen = 0;
   int           cycle_count = 0;
   int           send_idle_pct = 0;
   int           recv_stall_pct = 0;

   lowest_positive_quadratic_root_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Saturate a quotient to the signed 32-bit range.
   function automatic logic signed [127:0] clamp32(input logic signed [127:0] v);
      if (v > 128'sd2147483647) return 128'sd2147483647;
      if (v < -128'sd2147483648) return -128'sd2147483648;
      return v;
   endfunction

   function automatic root_result_type lowest_root(input logic signed [31:0] a,
                                                   input logic signed [31:0] b,
                                                   input logic signed [31:0] c,
                                                   input logic signed [31:0] lim);
      logic signed [127:0] aa, bb, cc, ll, disc, s, t, x1, x2, tmp;
      root_result_type r;
      aa = a;
      bb = b;
      cc = c;
      ll = lim;
      r = '0;
      if (a == 0) return r;
      disc = bb * bb - 128'sd4 * aa * cc;
      if (disc < 0) return r;
      s = 0;
      for (int i = 40; i >= 0; i--) begin
         t = s | (128'sd1 <<< i);
         if (t * t <= disc) s = t;
      end
      // signed division truncates toward zero, as the block does
      x1 = clamp32(((-bb - s) <<< FB) / (128'sd2 * aa));
      x2 = clamp32(((-bb + s) <<< FB) / (128'sd2 * aa));
      if (x1 > x2) begin
         tmp = x1;
         x1 = x2;
         x2 = tmp;
      end
      if (x1 > 0 && x1 < ll) begin
         r.found = 1'b1;
         r.root = x1[30:0];
      end else if (x2 > 0 && x2 < ll) begin
         r.found = 1'b1;
         r.root = x2[30:0];
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      $display("MISMATCH %s: got %h expected %h (result %0d)", what, got, want,
               results_seen);
   endtask

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_coefs(input logic signed [31:0] a, input logic signed [31:0] b,
                             input logic signed [31:0] c, input logic signed [31:0] lim);
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req_tdata = {lim, c, b, a};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      expected_roots.push_back(lowest_root(a, b, c, lim));
      items_sent++;
      @(negedge clock);
      req_tvalid = 1'b0;
      req_tdata = {$urandom, $urandom, $urandom, $urandom};
   endtask

   task automatic drain_results();
      while (expected_roots.size() != 0) @(negedge clock);
   endtask

   // receiver stall pattern
   always @(negedge clock) begin
      if (!reset) rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      root_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (expected_roots.size() == 0) begin
            report_mismatch("unexpected result", rsp_tdata, 32'h0);
         end else begin
            want = expected_roots.pop_front();
            if (rsp_tuser[0] != want.found)
               report_mismatch("found", {31'b0, rsp_tuser[0]}, {31'b0, want.found});
            if (rsp_tdata != {1'b0, want.root})
               report_mismatch("root_value", rsp_tdata, {1'b0, want.root});
            if (want.found) found_seen++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > MAX_CYCLES) begin
         $display("timeout with %0d results outstanding", expected_roots.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic test_corners();
      send_coefs(0, ONE, ONE, SMAX);                   // a zero
      send_coefs(ONE, 0, ONE, SMAX);                   // negative discriminant
      send_coefs(ONE, -3 * ONE, 2 * ONE, SMAX);        // roots 1 and 2
      send_coefs(ONE, -3 * ONE, 2 * ONE, 2 * ONE);     // upper root at limit
      send_coefs(ONE, -3 * ONE, 2 * ONE, ONE);         // both roots at or above
      send_coefs(ONE, -3 * ONE, 2 * ONE, 0);           // limit zero
      send_coefs(ONE, -3 * ONE, 2 * ONE, -ONE);        // negative limit
      send_coefs(-ONE, ONE, 2 * ONE, SMAX);            // roots -1 and 2, a negative
      send_coefs(ONE, -2 * ONE, ONE, SMAX);            // double root
      send_coefs(ONE, 0, 0, SMAX);                     // root at zero only
      send_coefs(1, SMIN, 0, SMAX);                    // quotient saturates high
      send_coefs(1, SMAX, 0, SMAX);                    // saturates low
      send_coefs(SMAX, SMAX, SMAX, SMAX);
      send_coefs(SMIN, SMIN, SMIN, SMIN);
      send_coefs(SMIN, SMAX, SMAX, SMAX);
      send_coefs(SMAX, SMIN, SMIN, SMAX);
      send_coefs(-1, -1, -1, -1);
      send_coefs(1, 1, -1, SMAX);
      send_coefs(ONE, 0, -4 * ONE, SMAX);              // roots -2 and 2
      send_coefs(ONE, ONE / 2, -ONE, 3 * ONE / 2);     // irrational roots
      drain_results();
   endtask

   // Mostly factored quadratics with known real roots, some fully random.
   task automatic test_random(input int count);
      logic signed [31:0] a, r1, r2, b, c, lim;
      logic signed [63:0] w;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(3) == 0) begin
            send_coefs($urandom, $urandom, $urandom, $urandom);
         end else begin
            a = $signed($urandom_range(1, 8 * ONE)) * ($urandom_range(1) ? 1 : -1);
            r1 = $signed($urandom_range(40 * ONE)) - 20 * ONE;
            r2 = $signed($urandom_range(40 * ONE)) - 20 * ONE;
            w = -(64'(a) * (64'(r1) + 64'(r2)));
            b = w[47:16];
            w = (64'(a) * 64'(r1)) >>> 16;
            w = (w * 64'(r2)) >>> 16;
            c = w[31:0];
            if ($urandom_range(4) == 0) c = c + $signed($urandom_range(2 * ONE)) - ONE;
            case ($urandom_range(3))
               0: lim = SMAX;
               1: lim = r1 + $signed($urandom_range(4)) - 2;
               2: lim = r2 + $signed($urandom_range(2 * ONE)) - ONE;
               default: lim = $urandom;
            endcase
            send_coefs(a, b, c, lim);
         end
      end
   endtask

   task automatic test_idle_phases();
      test_random(325);
      send_idle_pct = 86;
      test_random(325);
      drain_results();   // sender holds off until every result is in
      send_idle_pct = 0;
      recv_stall_pct = 86;
      test_random(325);
      send_idle_pct = 23;
      recv_stall_pct = 23;
      test_random(325);
   endtask

   initial begin
      req_tdata = '0;
      repeat (12) @(negedge clock);
      reset = 1'b0;
      test_corners();
      test_idle_phases();
      drain_results();
      repeat (LATENCY + 20) @(posedge clock);
      $display("Sent %0d items, checked %0d results, %0d with a root found.",
               items_sent, results_seen, found_seen);
      $display("Phases: no idling, sender idle, receiver stall, both idle.");
      if (error_count == 0 && expected_roots.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
